// ----- design/tpp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the tape pulse playback unit.
// No dependencies; imported by the interfaces, the top level and the checker.

package tpp_pkg;

    // Tape store geometry
    localparam int TAPE_DEPTH = 262144;
    localparam int TAPE_AW    = $clog2(TAPE_DEPTH);
    localparam int LEN_W      = TAPE_AW + 1;

    // Fixed field widths
    localparam int CMD_W  = 4;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 19;
    localparam int CNT_W  = 24;

    // Length in ticks that a zero byte stands for in format 0
    localparam int LONG_PULSE = 256 * 8;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic [APB_AW-3:0] {
        REG_TAPE_FORMAT = 1'b0,
        REG_UNUSED      = 1'b1
    } reg_idx_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 4'd0,
        CMD_MOTOR  = 4'd1,
        CMD_PLAY   = 4'd2,
        CMD_STOP   = 4'd3,
        CMD_REWIND = 4'd4,
        CMD_FFWD   = 4'd5,
        CMD_EJECT  = 4'd6,
        CMD_BLANK  = 4'd7,
        CMD_LOAD   = 4'd8,
        CMD_APPEND = 4'd9
    } cmd_t;

endpackage

// ----- design/tpp_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for commands and status beats.
// Depends on tpp_pkg.

interface tpp_cmd_if
    import tpp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic              motor_line;
    logic [BYTE_W-1:0] tape_byte;

    modport source (output valid, cmd, motor_line, tape_byte, input ready);
    modport sink   (input valid, cmd, motor_line, tape_byte, output ready);
endinterface

interface tpp_stat_if
    import tpp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             read_line;
    logic             sense_line;
    logic             is_playing;
    logic             motor_running;
    logic             tape_present;
    logic [POS_W-1:0] position;
    logic             end_of_tape;
    logic             store_overflow;

    modport source (output valid, read_line, sense_line, is_playing, motor_running,
                     tape_present, position, end_of_tape, store_overflow,
                     input ready);
    modport sink   (input valid, read_line, sense_line, is_playing, motor_running,
                     tape_present, position, end_of_tape, store_overflow,
                     output ready);
endinterface

// ----- design/tape_pulse_playback_unit.sv -----
`timescale 1ns / 1ps
// Top level of the tape pulse playback unit: command sequencer, transport state,
// pulse fetch from the tape store. Depends on tpp_pkg, tpp_ifs and tpp_ram.
//
//  channel   | dir | handshake      | beat contents
//  ----------+-----+----------------+--------------------------------------------
//  cmd_ch    | in  | valid / ready  | cmd, motor_line, tape_byte
//  stat_ch   | out | valid / ready  | read_line .. store_overflow, one per command
//  apb       | in  | psel / penable | tape_format_version at byte address 0
//
// One command at a time. A command without a tape read passes the execute and
// response states; a pulse fetch adds the byte fetch state, a format-1 long pulse
// the lo, mid and hi fetch states: four serial reads of the single-read-port store.
// A stalled status beat holds the sequencer until the sink takes it.
// Reset clears all transport state; the tape store itself is not cleared.

module tape_pulse_playback_unit
    import tpp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    tpp_cmd_if.sink           cmd_ch,
    tpp_stat_if.source        stat_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH_B,
        S_FETCH_LO,
        S_FETCH_MID,
        S_FETCH_HI,
        S_RESP
    } state_t;

    state_t             state_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic               mline_reg;
    logic [BYTE_W-1:0]  byte_reg;

    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               level_reg;
    logic               play_reg;
    logic               motor_reg;
    logic               loaded_reg;
    logic               sense_reg;
    logic               fmt_reg;
    logic               eot_reg;
    logic               ovf_reg;
    logic [BYTE_W-1:0]  lo_reg;
    logic [BYTE_W-1:0]  mid_reg;

    logic               out_valid_reg;
    logic               out_read_reg;
    logic               out_sense_reg;
    logic               out_play_reg;
    logic               out_motor_reg;
    logic               out_tape_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic               out_eot_reg;
    logic               out_ovf_reg;

    logic               ram_we;
    logic               ram_re;
    logic [BYTE_W-1:0]  ram_rdata;
    logic               cfg_wr;
    logic               active;
    logic               pos_at_end;
    logic               long_fits;
    logic               out_free;
    logic [CNT_W-1:0]   long_count;

    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = (reg_idx_t'(paddr[APB_AW-1:2]) == REG_TAPE_FORMAT)
                        ? APB_DW'(fmt_reg) : '0;
    assign active     = play_reg && motor_reg && loaded_reg;
    assign pos_at_end = (pos_reg >= len_reg);
    assign long_fits  = (({1'b0, pos_reg} + (LEN_W + 1)'(3)) <= {1'b0, len_reg});
    assign out_free   = !out_valid_reg || stat_ch.ready;
    assign long_count = {ram_rdata, mid_reg, lo_reg};

    assign cmd_ch.ready = (state_reg == S_IDLE);

    always_comb
    begin
        ram_we = (state_reg == S_EXEC) && (cmd_t'(cmd_reg) == CMD_APPEND)
                 && (len_reg < LEN_W'(TAPE_DEPTH));
        unique case (state_reg)
            S_EXEC:      ram_re = (cmd_t'(cmd_reg) == CMD_TICK) && active
                                  && (cnt_reg == '0) && !pos_at_end;
            S_FETCH_B:   ram_re = (ram_rdata == '0) && fmt_reg && long_fits;
            S_FETCH_LO:  ram_re = 1'b1;
            S_FETCH_MID: ram_re = 1'b1;
            default:     ram_re = 1'b0;
        endcase
    end

    tpp_ram #(
        .DEPTH (TAPE_DEPTH),
        .WIDTH (BYTE_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (len_reg[TAPE_AW-1:0]),
        .wdata (byte_reg),
        .re    (ram_re),
        .raddr (pos_reg[TAPE_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            level_reg     <= 1'b1;
            play_reg      <= 1'b0;
            motor_reg     <= 1'b0;
            loaded_reg    <= 1'b0;
            sense_reg     <= 1'b1;
            fmt_reg       <= 1'b0;
            eot_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // the response state reloads the slot itself
            if (stat_ch.ready && (state_reg != S_RESP))
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr && (reg_idx_t'(paddr[APB_AW-1:2]) == REG_TAPE_FORMAT))
            begin
                fmt_reg <= pwdata[0];
            end
            else if ((state_reg == S_EXEC) && (cmd_t'(cmd_reg) == CMD_BLANK))
            begin
                fmt_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_ch.valid)
                    begin
                        cmd_reg   <= cmd_ch.cmd;
                        mline_reg <= cmd_ch.motor_line;
                        byte_reg  <= cmd_ch.tape_byte;
                        eot_reg   <= 1'b0;
                        ovf_reg   <= 1'b0;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_RESP;
                    unique case (cmd_t'(cmd_reg))
                        CMD_TICK:
                        begin
                            if (active)
                            begin
                                if (cnt_reg != '0)
                                begin
                                    cnt_reg <= cnt_reg - CNT_W'(1);
                                end
                                else if (pos_at_end)
                                begin
                                    play_reg  <= 1'b0;
                                    sense_reg <= 1'b1;
                                    level_reg <= 1'b1;
                                    eot_reg   <= 1'b1;
                                end
                                else
                                begin
                                    pos_reg   <= pos_reg + LEN_W'(1);
                                    state_reg <= S_FETCH_B;
                                end
                            end
                        end
                        CMD_MOTOR:  motor_reg <= !mline_reg;
                        CMD_PLAY:
                        begin
                            if (loaded_reg)
                            begin
                                play_reg  <= 1'b1;
                                sense_reg <= 1'b0;
                            end
                        end
                        CMD_STOP:
                        begin
                            play_reg  <= 1'b0;
                            sense_reg <= 1'b1;
                            level_reg <= 1'b1;
                        end
                        CMD_REWIND:
                        begin
                            pos_reg <= '0;
                            cnt_reg <= '0;
                        end
                        CMD_FFWD:
                        begin
                            if (loaded_reg)
                            begin
                                pos_reg <= len_reg;
                            end
                        end
                        CMD_EJECT:
                        begin
                            len_reg    <= '0;
                            loaded_reg <= 1'b0;
                            pos_reg    <= '0;
                            play_reg   <= 1'b0;
                            cnt_reg    <= '0;
                            level_reg  <= 1'b1;
                            sense_reg  <= 1'b1;
                        end
                        CMD_BLANK:
                        begin
                            len_reg    <= '0;
                            loaded_reg <= 1'b1;
                            pos_reg    <= '0;
                            play_reg   <= 1'b0;
                        end
                        CMD_LOAD:
                        begin
                            len_reg    <= '0;
                            loaded_reg <= 1'b1;
                            pos_reg    <= '0;
                            play_reg   <= 1'b0;
                            cnt_reg    <= '0;
                            level_reg  <= 1'b1;
                        end
                        CMD_APPEND:
                        begin
                            if (ram_we)
                            begin
                                len_reg <= len_reg + LEN_W'(1);
                            end
                            else
                            begin
                                ovf_reg <= 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_FETCH_B:
                begin
                    if (ram_rdata != '0)
                    begin
                        cnt_reg   <= CNT_W'({ram_rdata, 3'b000}) - CNT_W'(1);
                        level_reg <= !level_reg;
                        state_reg <= S_RESP;
                    end
                    else if (!fmt_reg)
                    begin
                        cnt_reg   <= CNT_W'(LONG_PULSE - 1);
                        level_reg <= !level_reg;
                        state_reg <= S_RESP;
                    end
                    else if (!long_fits)
                    begin
                        // truncated long pulse: zero byte stays consumed
                        play_reg  <= 1'b0;
                        sense_reg <= 1'b1;
                        level_reg <= 1'b1;
                        eot_reg   <= 1'b1;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        pos_reg   <= pos_reg + LEN_W'(1);
                        state_reg <= S_FETCH_LO;
                    end
                end
                S_FETCH_LO:
                begin
                    lo_reg    <= ram_rdata;
                    pos_reg   <= pos_reg + LEN_W'(1);
                    state_reg <= S_FETCH_MID;
                end
                S_FETCH_MID:
                begin
                    mid_reg   <= ram_rdata;
                    pos_reg   <= pos_reg + LEN_W'(1);
                    state_reg <= S_FETCH_HI;
                end
                S_FETCH_HI:
                begin
                    state_reg <= S_RESP;
                    if (long_count == '0)
                    begin
                        play_reg  <= 1'b0;
                        sense_reg <= 1'b1;
                        level_reg <= 1'b1;
                        eot_reg   <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg   <= long_count - CNT_W'(1);
                        level_reg <= !level_reg;
                    end
                end
                S_RESP:
                begin
                    // hold until the status slot is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_read_reg  <= level_reg;
                        out_sense_reg <= sense_reg;
                        out_play_reg  <= play_reg;
                        out_motor_reg <= motor_reg;
                        out_tape_reg  <= loaded_reg;
                        out_pos_reg   <= POS_W'(pos_reg);
                        out_eot_reg   <= eot_reg;
                        out_ovf_reg   <= ovf_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign stat_ch.valid          = out_valid_reg;
    assign stat_ch.read_line      = out_read_reg;
    assign stat_ch.sense_line     = out_sense_reg;
    assign stat_ch.is_playing     = out_play_reg;
    assign stat_ch.motor_running  = out_motor_reg;
    assign stat_ch.tape_present   = out_tape_reg;
    assign stat_ch.position       = out_pos_reg;
    assign stat_ch.end_of_tape    = out_eot_reg;
    assign stat_ch.store_overflow = out_ovf_reg;

endmodule

// ----- design/tpp_ram.sv -----
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; holds the tape image for the top level.

module tpp_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/tpp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the tape pulse playback unit, bound to the top level.
// Depends on tpp_pkg and on the top level's ports.

module tpp_checker
    import tpp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic read_line,
    input logic sense_line,
    input logic is_playing,
    input logic tape_present,
    input logic [POS_W-1:0] position
);

    logic in_acc;
    logic out_stall;

    assign in_acc    = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    // one command in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n) in_acc |=> !in_acc)
        else $error("command accepted on back-to-back cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_playing |-> tape_present)
        else $error("playing without a tape");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_playing |-> !sense_line)
        else $error("playing with sense released");

    assert property (@(posedge clk) disable iff (!rst_n) out_stall |=> out_valid)
        else $error("status beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_stall |=> $stable(position) && $stable(read_line))
        else $error("status beat changed while stalled");

endmodule

bind tape_pulse_playback_unit tpp_checker u_tpp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (cmd_ch.valid),
    .in_ready     (cmd_ch.ready),
    .out_valid    (stat_ch.valid),
    .out_ready    (stat_ch.ready),
    .read_line    (stat_ch.read_line),
    .sense_line   (stat_ch.sense_line),
    .is_playing   (stat_ch.is_playing),
    .tape_present (stat_ch.tape_present),
    .position     (stat_ch.position)
);
